// ===== rtl/rds_group_decoder_top_macros.svh =====
// Assertion macros for the RDS group decoder checker.
// Depends on nothing; included by the checker file.
`ifndef RDS_GROUP_DECODER_TOP_MACROS_SVH
`define RDS_GROUP_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RGD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rgd_pkg.sv =====
// Shared types, constants and helper functions of the RDS group decoder.
// No dependencies; imported by the ALU, the text RAM, the top level, the checker and the bench.
package rgd_pkg;

	localparam int TEXT_CHARS = 64;
	localparam int NAME_CHARS = 8;
	localparam int TEXT_ROWS  = TEXT_CHARS / 4;
	localparam int ROW_W      = $clog2(TEXT_ROWS);
	localparam int CNT_W      = $clog2(TEXT_CHARS) + 1;
	localparam int ACC_W      = 13;

	localparam logic [1:0] KIND_NAME = 2'd0;
	localparam logic [1:0] KIND_TEXT = 2'd1;
	localparam logic [1:0] KIND_TIME = 2'd2;

	localparam logic [3:0] GRP_NAME = 4'd0;
	localparam logic [3:0] GRP_TEXT = 4'd2;
	localparam logic [3:0] GRP_TIME = 4'd4;

	localparam logic [1:0] REG_NAME_EN = 2'd0;
	localparam logic [1:0] REG_TEXT_EN = 2'd1;
	localparam logic [1:0] REG_TIME_EN = 2'd2;

	localparam logic signed [ACC_W-1:0] MIN_PER_DAY  = 13'sd1440;
	localparam logic signed [ACC_W-1:0] MIN_PER_HOUR = 13'sd60;

	typedef logic [NAME_CHARS-1:0][7:0] name_t;

	typedef enum logic [0:0] {ALU_ADD, ALU_SUB} alu_op_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CLR, S_EMPTY_NAME, S_EMPTY_TEXT, S_DECODE, S_NAME_CHK,
		S_STR_RD, S_STR_OUT, S_STR_FLUSH, S_TEXT_WR,
		S_T_ADD_OFS, S_T_WRAP, S_T_CMP, S_T_DIV, S_T_EMIT
	} state_t;

	// String compare: equal up to and including the first zero byte.
	function automatic logic name_eq(name_t x, name_t y);
		logic eq;
		logic done;
		eq = 1'b1;
		done = 1'b0;
		for (int i = 0; i < NAME_CHARS; i++) begin
			if (!done) begin
				if (x[i] != y[i]) begin
					eq = 1'b0;
					done = 1'b1;
				end else if (x[i] == 8'd0) begin
					done = 1'b1;
				end
			end
		end
		return eq;
	endfunction

endpackage

// ===== rtl/rgd_ifs.sv =====
// Valid/ready channel interfaces: RDS groups in, decoded events out.
// Depends on nothing.
interface rgd_grp_if;
	logic        valid;
	logic        ready;
	logic [15:0] block_a;
	logic [15:0] block_b;
	logic [15:0] block_c;
	logic [15:0] block_d;
	modport source (output valid, block_a, block_b, block_c, block_d, input ready);
	modport sink (input valid, block_a, block_b, block_c, block_d, output ready);
endinterface

interface rgd_evt_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_kind;
	logic       char_present;
	logic [7:0] char_code;
	logic [4:0] hours;
	logic [5:0] minutes;
	logic       last;
	modport source (output valid, event_kind, char_present, char_code, hours, minutes,
		last, input ready);
	modport sink (input valid, event_kind, char_present, char_code, hours, minutes,
		last, output ready);
endinterface

// ===== rtl/rgd_alu.sv =====
// Shared signed add/subtract unit for the clock time sequence.
// Depends on rgd_pkg.
module rgd_alu import rgd_pkg::*; (
	input  alu_op_t                 op,
	input  logic signed [ACC_W-1:0] a,
	input  logic signed [ACC_W-1:0] b,
	output logic signed [ACC_W-1:0] y
);
	always_comb begin
		unique case (op)
			ALU_ADD: y = a + b;
			ALU_SUB: y = a - b;
			default: y = a;
		endcase
	end
endmodule

// ===== rtl/rgd_text_ram.sv =====
// Radiotext buffer: one row of four characters per address, registered read.
// Depends on rgd_pkg.
module rgd_text_ram import rgd_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic [ROW_W-1:0] waddr,
	input  logic [31:0]      wdata,
	input  logic [ROW_W-1:0] raddr,
	output logic [31:0]      rdata
);
	logic [31:0] mem [TEXT_ROWS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/rds_group_decoder_top.sv =====
// RDS group decoder: takes one group (blocks A..D) per beat and reports
// service name, radiotext and clock time events, one event per output beat.
// A group is taken only while the sequencer is idle. For a clock time group
// the shared adder works out the local time and then divides it by 60 one
// subtraction a cycle; a reported string goes out one character at a time,
// each a read of the name or text buffer, then the output beat, which can
// stall on the output side. Text rows carry valid bits, so the buffer needs
// no clearing pass. Depends on rgd_pkg, rgd_ifs, rgd_alu and rgd_text_ram.
module rds_group_decoder_top import rgd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	rgd_grp_if.sink     grp,
	rgd_evt_if.source   evt,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [0:0]  cfg_wdata
);
	state_t state_q, state_d;

	logic [15:0] b_q, c_q, d_q;
	logic name_en_q, text_en_q, time_en_q;
	name_t first_q, conf_q, pub_q;
	logic [TEXT_ROWS-1:0] txt_vld_q;
	logic ab_q;
	logic [5:0] idx_q;
	logic [10:0] last_time_q;

	logic str_text_q;
	logic [CNT_W-1:0] cnt_q;
	logic held_q;
	logic [7:0] held_chr_q, name_chr_q;
	logic row_vld_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [4:0] hrs_q;

	logic ov_q;
	logic [1:0] ok_q;
	logic op_q, ol_q;
	logic [7:0] oc_q;
	logic [4:0] oh_q;
	logic [5:0] om_q;

	logic [3:0] grp_type;
	logic [2:0] npos;
	logic [5:0] tpos;
	logic matched, slot_free, at_end;
	logic [7:0] cur_chr;
	logic [31:0] ram_rdata;
	logic [ROW_W-1:0] rd_row;
	logic ram_we;

	logic emit, e_present, e_last;
	logic [1:0] e_kind;
	logic [7:0] e_chr;
	logic [4:0] e_hrs;
	logic [5:0] e_min;

	alu_op_t alu_op;
	logic signed [ACC_W-1:0] alu_a, alu_b, alu_y;
	logic [10:0] hrs60;
	logic [9:0] ofs30;

	assign grp_type  = b_q[15:12];
	assign npos      = {b_q[1:0], 1'b0};
	assign tpos      = {b_q[3:0], 2'b00};
	assign matched   = (first_q[npos] == d_q[15:8]) && (first_q[{b_q[1:0], 1'b1}] == d_q[7:0]);
	assign slot_free = !ov_q || evt.ready;
	assign at_end    = cnt_q == (str_text_q ? CNT_W'(TEXT_CHARS) : CNT_W'(NAME_CHARS));
	assign rd_row    = cnt_q[ROW_W+1:2];
	assign hrs60     = 11'({c_q[0], d_q[15:12]}) * 11'd60;
	assign ofs30     = 10'(d_q[4:0]) * 10'd30;
	assign grp.ready = state_q == S_IDLE;

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0: cur_chr = ram_rdata[31:24];
			2'd1: cur_chr = ram_rdata[23:16];
			2'd2: cur_chr = ram_rdata[15:8];
			default: cur_chr = ram_rdata[7:0];
		endcase
		if (!str_text_q) begin
			cur_chr = name_chr_q;
		end else if (!row_vld_q) begin
			cur_chr = 8'd0;
		end
	end

	rgd_text_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (b_q[3:0]),
		.wdata ({c_q, d_q}),
		.raddr (rd_row),
		.rdata (ram_rdata)
	);

	rgd_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	// Next state, event and shared unit control.
	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		e_kind    = str_text_q ? KIND_TEXT : KIND_NAME;
		e_present = 1'b0;
		e_chr     = 8'd0;
		e_hrs     = 5'd0;
		e_min     = 6'd0;
		e_last    = 1'b1;
		ram_we    = 1'b0;
		alu_op    = ALU_ADD;
		alu_a     = acc_q;
		alu_b     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (grp.valid) begin
					state_d = (grp.block_a == 16'd0) ? S_CLR : S_DECODE;
				end
			end
			S_CLR: state_d = S_EMPTY_NAME;
			S_EMPTY_NAME: begin
				if (!name_en_q) begin
					state_d = S_EMPTY_TEXT;
				end else if (slot_free) begin
					emit = 1'b1;
					e_kind = KIND_NAME;
					state_d = S_EMPTY_TEXT;
				end
			end
			S_EMPTY_TEXT: begin
				if (!text_en_q) begin
					state_d = S_DECODE;
				end else if (slot_free) begin
					emit = 1'b1;
					e_kind = KIND_TEXT;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				alu_a = ACC_W'(d_q[11:6]);
				alu_b = ACC_W'(hrs60);
				state_d = S_IDLE;
				if (grp_type == GRP_NAME) begin
					if (name_en_q && matched && b_q[1:0] == 2'd3) begin
						state_d = S_NAME_CHK;
					end
				end else if (grp_type == GRP_TEXT && !b_q[11]) begin
					if (text_en_q) begin
						state_d = (tpos < idx_q) ? S_STR_RD : S_TEXT_WR;
					end
				end else if (grp_type == GRP_TIME && !b_q[11]) begin
					if (time_en_q) begin
						state_d = S_T_ADD_OFS;
					end
				end
			end
			S_NAME_CHK: begin
				state_d = (name_eq(first_q, conf_q) && !name_eq(conf_q, pub_q)) ?
					S_STR_RD : S_IDLE;
			end
			S_STR_RD: state_d = at_end ? S_STR_FLUSH : S_STR_OUT;
			S_STR_OUT: begin
				// Hold one character back so the final one can carry last.
				if (!held_q) begin
					if (cur_chr == 8'd0) begin
						if (slot_free) begin
							emit = 1'b1;
							state_d = str_text_q ? S_TEXT_WR : S_IDLE;
						end
					end else begin
						state_d = S_STR_RD;
					end
				end else if (slot_free) begin
					emit = 1'b1;
					e_present = 1'b1;
					e_chr = held_chr_q;
					e_last = cur_chr == 8'd0;
					if (cur_chr == 8'd0) begin
						state_d = str_text_q ? S_TEXT_WR : S_IDLE;
					end else begin
						state_d = S_STR_RD;
					end
				end
			end
			S_STR_FLUSH: begin
				if (slot_free) begin
					emit = 1'b1;
					e_present = 1'b1;
					e_chr = held_chr_q;
					state_d = str_text_q ? S_TEXT_WR : S_IDLE;
				end
			end
			S_TEXT_WR: begin
				ram_we = 1'b1;
				state_d = S_IDLE;
			end
			S_T_ADD_OFS: begin
				alu_op = d_q[5] ? ALU_SUB : ALU_ADD;
				alu_b = ACC_W'(ofs30);
				state_d = S_T_WRAP;
			end
			S_T_WRAP: begin
				if (acc_q < 0) begin
					alu_b = MIN_PER_DAY;
				end else if (acc_q >= MIN_PER_DAY) begin
					alu_op = ALU_SUB;
					alu_b = MIN_PER_DAY;
				end
				state_d = S_T_CMP;
			end
			S_T_CMP: state_d = (acc_q[10:0] == last_time_q) ? S_IDLE : S_T_DIV;
			S_T_DIV: begin
				alu_op = ALU_SUB;
				alu_b = MIN_PER_HOUR;
				if (alu_y[ACC_W-1]) begin
					state_d = S_T_EMIT;
				end
			end
			S_T_EMIT: begin
				if (slot_free) begin
					emit = 1'b1;
					e_kind = KIND_TIME;
					e_hrs = hrs_q;
					e_min = acc_q[5:0];
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			name_en_q   <= 1'b0;
			text_en_q   <= 1'b0;
			time_en_q   <= 1'b0;
			first_q     <= '0;
			conf_q      <= '0;
			pub_q       <= '0;
			txt_vld_q   <= '0;
			ab_q        <= 1'b0;
			idx_q       <= '0;
			last_time_q <= '0;
			ov_q        <= 1'b0;
			held_q      <= 1'b0;
			str_text_q  <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_NAME_EN: name_en_q <= cfg_wdata[0];
					REG_TEXT_EN: text_en_q <= cfg_wdata[0];
					REG_TIME_EN: time_en_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (evt.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					first_q     <= '0;
					conf_q      <= '0;
					pub_q       <= '0;
					txt_vld_q   <= '0;
					ab_q        <= 1'b0;
					idx_q       <= '0;
					last_time_q <= '0;
				end
				S_DECODE: begin
					cnt_q <= '0;
					held_q <= 1'b0;
					str_text_q <= grp_type == GRP_TEXT;
					if (grp_type == GRP_NAME && name_en_q) begin
						if (matched) begin
							conf_q[npos] <= d_q[15:8];
							conf_q[{b_q[1:0], 1'b1}] <= d_q[7:0];
						end else begin
							first_q[npos] <= d_q[15:8];
							first_q[{b_q[1:0], 1'b1}] <= d_q[7:0];
						end
					end
				end
				S_NAME_CHK: begin
					if (name_eq(first_q, conf_q) && !name_eq(conf_q, pub_q)) begin
						pub_q <= conf_q;
					end
				end
				S_STR_OUT: begin
					if (state_d == S_STR_RD) begin
						held_q <= 1'b1;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_TEXT_WR: begin
					idx_q <= tpos;
					if (b_q[4] != ab_q) begin
						ab_q <= b_q[4];
						txt_vld_q <= '0;
						txt_vld_q[b_q[3:0]] <= 1'b1;
					end else begin
						txt_vld_q[b_q[3:0]] <= 1'b1;
					end
				end
				S_T_CMP: begin
					if (acc_q[10:0] != last_time_q) begin
						last_time_q <= acc_q[10:0];
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (grp.valid && grp.ready) begin
			b_q <= grp.block_b;
			c_q <= grp.block_c;
			d_q <= grp.block_d;
		end
		if (emit) begin
			ok_q <= e_kind;
			op_q <= e_present;
			oc_q <= e_chr;
			oh_q <= e_hrs;
			om_q <= e_min;
			ol_q <= e_last;
		end
		if (state_q == S_STR_RD) begin
			name_chr_q <= pub_q[cnt_q[2:0]];
			row_vld_q <= txt_vld_q[rd_row];
		end
		if (state_q == S_STR_OUT && state_d == S_STR_RD) begin
			held_chr_q <= cur_chr;
		end
		if (state_q == S_DECODE || state_q == S_T_ADD_OFS || state_q == S_T_WRAP) begin
			acc_q <= alu_y;
		end
		if (state_q == S_T_CMP) begin
			hrs_q <= '0;
		end
		if (state_q == S_T_DIV && !alu_y[ACC_W-1]) begin
			acc_q <= alu_y;
			hrs_q <= hrs_q + 1'b1;
		end
	end

	assign evt.valid        = ov_q;
	assign evt.event_kind   = ok_q;
	assign evt.char_present = op_q;
	assign evt.char_code    = oc_q;
	assign evt.hours        = oh_q;
	assign evt.minutes      = om_q;
	assign evt.last         = ol_q;
endmodule

// ===== rtl/rgd_checker.sv =====
// Port-level checks on the decoder's event channel, bound to the top level.
// Depends on rgd_pkg and rds_group_decoder_top_macros.svh.
`include "rds_group_decoder_top_macros.svh"
module rgd_checker import rgd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       ready,
	input logic [1:0] event_kind,
	input logic       char_present,
	input logic [7:0] char_code,
	input logic [4:0] hours,
	input logic [5:0] minutes,
	input logic       last
);
	`RGD_ASSERT_NEXT(a_stall_hold, clk, arst_n, valid && !ready, valid && $stable(char_code), "stalled beat changed")
	`RGD_ASSERT_NOW(a_time_single, clk, arst_n, valid && event_kind == KIND_TIME, last && !char_present && char_code == 8'd0, "time beat malformed")
	`RGD_ASSERT_NOW(a_empty_last, clk, arst_n, valid && !char_present, last && char_code == 8'd0, "empty beat malformed")
	`RGD_ASSERT_NOW(a_time_range, clk, arst_n, valid, hours < 5'd24 && minutes < 6'd60, "time out of range")
endmodule

bind rds_group_decoder_top rgd_checker u_rgd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.valid        (evt.valid),
	.ready        (evt.ready),
	.event_kind   (evt.event_kind),
	.char_present (evt.char_present),
	.char_code    (evt.char_code),
	.hours        (evt.hours),
	.minutes      (evt.minutes),
	.last         (evt.last)
);

// ===== dv/tb_rds_group_decoder_top.sv =====
// Self-checking testbench for rds_group_decoder_top: drives RDS groups and checks the
// name, radiotext and clock time events against a predictor kept inside the bench.
// Depends on rgd_pkg, rgd_ifs and the decoder RTL.
`timescale 1ns / 100ps

module tb_rds_group_decoder_top;
	import rgd_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 200;

	typedef struct packed {
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		logic [15:0] d;
	} group_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       present;
		logic [7:0] code;
		logic [4:0] hours;
		logic [5:0] minutes;
		logic       last;
	} rds_event_t;

	typedef logic [7:0] text_chars_t [TEXT_CHARS];
	typedef logic [7:0] name_chars_t [NAME_CHARS];

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [0:0] cfg_wdata;

	rgd_grp_if grp ();
	rgd_evt_if evt ();

	rds_group_decoder_top uut (
		.clk(clk), .arst_n(arst_n), .grp(grp.sink), .evt(evt.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	group_t pending_groups[$];
	rds_event_t expected_events[$];

	// decoder state as the bench sees it
	logic name_en, text_en, time_en;
	name_chars_t name_first, name_conf, name_pub;
	text_chars_t text_buf;
	logic text_ab;
	logic [5:0] text_last_pos;
	logic [10:0] last_mins;

	int src_idle_pct, snk_idle_pct, snk_hold;
	bit beat_taken;
	int errors, groups_sent, events_seen;

	always #6 clk = ~clk;

	initial begin
		#36_000_000;
		$display("timeout with %0d groups pending, %0d events outstanding",
			pending_groups.size(), expected_events.size());
		$display("** rds_group_decoder_top: FAILED **");
		$finish;
	end

	function automatic void clear_model();
		for (int i = 0; i < NAME_CHARS; i++) begin
			name_first[i] = 8'd0;
			name_conf[i] = 8'd0;
			name_pub[i] = 8'd0;
		end
		for (int i = 0; i < TEXT_CHARS; i++) text_buf[i] = 8'd0;
		text_ab = 1'b0;
		text_last_pos = 6'd0;
		last_mins = 11'd0;
	endfunction

	function automatic void push_event(logic [1:0] kind, logic present, logic [7:0] code,
			logic [4:0] hrs, logic [5:0] mins, logic last);
		rds_event_t e;
		e.kind = kind;
		e.present = present;
		e.code = code;
		e.hours = hrs;
		e.minutes = mins;
		e.last = last;
		expected_events.push_back(e);
	endfunction

	function automatic void push_string(logic [1:0] kind, text_chars_t s, int size);
		int len;
		len = 0;
		while (len < size && s[len] != 8'd0) len++;
		if (len == 0) push_event(kind, 1'b0, 8'd0, 5'd0, 6'd0, 1'b1);
		for (int i = 0; i < len; i++)
			push_event(kind, 1'b1, s[i], 5'd0, 6'd0, i == len - 1);
	endfunction

	function automatic logic names_match(name_chars_t x, name_chars_t y);
		for (int i = 0; i < NAME_CHARS; i++) begin
			if (x[i] != y[i]) return 1'b0;
			if (x[i] == 8'd0) return 1'b1;
		end
		return 1'b1;
	endfunction

	function automatic void decode_group(group_t g);
		text_chars_t padded;
		int pos, mins, ofs;
		logic [3:0] kind_of_group;
		logic ver;
		kind_of_group = g.b[15:12];
		ver = g.b[11];
		for (int i = 0; i < TEXT_CHARS; i++) padded[i] = 8'd0;
		if (g.a == 16'd0) begin
			clear_model();
			if (name_en) push_string(KIND_NAME, padded, 0);
			if (text_en) push_string(KIND_TEXT, padded, 0);
		end
		if (kind_of_group == GRP_NAME) begin
			if (!name_en) return;
			pos = g.b[1:0] * 2;
			if (name_first[pos] == g.d[15:8] && name_first[pos + 1] == g.d[7:0]) begin
				name_conf[pos] = g.d[15:8];
				name_conf[pos + 1] = g.d[7:0];
				if (pos == 6 && names_match(name_first, name_conf)
						&& !names_match(name_conf, name_pub)) begin
					name_pub = name_conf;
					for (int i = 0; i < NAME_CHARS; i++) padded[i] = name_pub[i];
					push_string(KIND_NAME, padded, NAME_CHARS);
				end
			end else begin
				name_first[pos] = g.d[15:8];
				name_first[pos + 1] = g.d[7:0];
			end
		end else if (kind_of_group == GRP_TEXT && !ver) begin
			if (!text_en) return;
			pos = g.b[3:0] * 4;
			if (pos < text_last_pos) push_string(KIND_TEXT, text_buf, TEXT_CHARS);
			text_last_pos = pos[5:0];
			// a new A/B flag starts a fresh message
			if (g.b[4] != text_ab) begin
				text_ab = g.b[4];
				for (int i = 0; i < TEXT_CHARS; i++) text_buf[i] = 8'd0;
			end
			text_buf[pos] = g.c[15:8];
			text_buf[pos + 1] = g.c[7:0];
			text_buf[pos + 2] = g.d[15:8];
			text_buf[pos + 3] = g.d[7:0];
		end else if (kind_of_group == GRP_TIME && !ver) begin
			if (!time_en) return;
			ofs = g.d[5:0];
			mins = g.d[11:6] + 60 * {g.c[0], g.d[15:12]};
			if (ofs[5]) mins -= 30 * ofs[4:0];
			else mins += 30 * ofs[4:0];
			mins %= 1440;
			if (mins < 0) mins += 1440;
			if (mins[10:0] != last_mins) begin
				last_mins = mins[10:0];
				push_event(KIND_TIME, 1'b0, 8'd0, 5'(mins / 60), 6'(mins % 60), 1'b1);
			end
		end
	endfunction

	// group side: predict at acceptance, hold an offered beat until taken
	always @(posedge clk) begin
		beat_taken = 1'b0;
		if (arst_n && grp.valid && grp.ready) begin
			decode_group(pending_groups.pop_front());
			groups_sent++;
			beat_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			grp.valid <= 1'b0;
		end else if (!(grp.valid && !beat_taken)) begin
			if (pending_groups.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
				grp.valid <= 1'b1;
				grp.block_a <= pending_groups[0].a;
				grp.block_b <= pending_groups[0].b;
				grp.block_c <= pending_groups[0].c;
				grp.block_d <= pending_groups[0].d;
			end else begin
				grp.valid <= 1'b0;
			end
		end
	end

	// event side
	always @(negedge clk) begin
		if (!arst_n) begin
			evt.ready <= 1'b0;
		end else if (snk_hold > 0) begin
			evt.ready <= 1'b0;
			snk_hold <= snk_hold - 1;
		end else begin
			evt.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		rds_event_t want;
		if (arst_n && evt.valid && evt.ready) begin
			events_seen++;
			if (expected_events.size() == 0) begin
				$error("unexpected event kind=%0d code=%0h", evt.event_kind, evt.char_code);
				errors++;
			end else begin
				want = expected_events.pop_front();
				if (evt.event_kind !== want.kind) begin
					$error("event_kind: expected %0d, got %0d", want.kind, evt.event_kind);
					errors++;
				end
				if (evt.char_present !== want.present) begin
					$error("char_present: expected %0d, got %0d", want.present,
						evt.char_present);
					errors++;
				end
				if (evt.char_code !== want.code) begin
					$error("char_code: expected %0h, got %0h", want.code, evt.char_code);
					errors++;
				end
				if (evt.hours !== want.hours) begin
					$error("hours: expected %0d, got %0d", want.hours, evt.hours);
					errors++;
				end
				if (evt.minutes !== want.minutes) begin
					$error("minutes: expected %0d, got %0d", want.minutes, evt.minutes);
					errors++;
				end
				if (evt.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, evt.last);
					errors++;
				end
			end
		end
	end

	task automatic queue_group(logic [15:0] a, logic [15:0] b, logic [15:0] c,
			logic [15:0] d);
		group_t g;
		g.a = a;
		g.b = b;
		g.c = c;
		g.d = d;
		pending_groups.push_back(g);
	endtask

	task automatic drain();
		wait (pending_groups.size() == 0 && !grp.valid && expected_events.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == REG_NAME_EN) name_en = val;
		else if (idx == REG_TEXT_EN) text_en = val;
		else if (idx == REG_TIME_EN) time_en = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_enables(logic n, logic t, logic m);
		write_reg(REG_NAME_EN, n);
		write_reg(REG_TEXT_EN, t);
		write_reg(REG_TIME_EN, m);
	endtask

	function automatic logic [15:0] some_a();
		return ($urandom_range(39) == 0) ? 16'd0 : 16'($urandom_range(65535, 1));
	endfunction

	function automatic logic [7:0] some_char();
		int r;
		r = $urandom_range(19);
		if (r == 0) return 8'd0;
		if (r < 4) return 8'($urandom_range(255));
		return 8'($urandom_range(90, 65));
	endfunction

	// service name: two passes over the four segments, sometimes broken
	task automatic random_name();
		logic [7:0] chars [NAME_CHARS];
		logic [1:0] seg;
		for (int i = 0; i < NAME_CHARS; i++) chars[i] = some_char();
		for (int pass = 0; pass < 2; pass++)
			for (int s = 0; s < 4; s++) begin
				seg = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : 2'(s);
				queue_group(some_a(), {GRP_NAME, 1'($urandom), 9'($urandom), seg},
					16'($urandom), {chars[seg * 2], chars[seg * 2 + 1]});
			end
	endtask

	// radiotext: ascending segments, then the index goes back on the next message
	task automatic random_text();
		int segs;
		logic ab;
		segs = ($urandom_range(5) == 0) ? 16 : $urandom_range(6, 1);
		ab = 1'($urandom_range(3) == 0);
		for (int s = 0; s < segs; s++)
			queue_group(some_a(), {GRP_TEXT, 1'b0, 6'($urandom), ab ^ 1'($urandom_range(15) == 0),
				4'(s)}, {some_char(), some_char()}, {some_char(), some_char()});
	endtask

	task automatic random_time();
		logic [15:0] d;
		d = ($urandom_range(3) == 0) ? 16'($urandom)
			: {4'($urandom_range(15)), 6'($urandom_range(59)), 1'($urandom), 5'($urandom_range(4))};
		queue_group(some_a(), {GRP_TIME, 1'b0, 11'($urandom)}, 16'($urandom), d);
		if ($urandom_range(3) == 0)
			queue_group(some_a(), {GRP_TIME, 1'b0, 11'($urandom)}, 16'($urandom), d);
	endtask

	task automatic random_phase(int target);
		int start;
		start = groups_sent + pending_groups.size();
		while (groups_sent + pending_groups.size() - start < target) begin
			case ($urandom_range(9))
				0, 1, 2: random_name();
				3, 4, 5: random_text();
				6, 7: random_time();
				default: queue_group(some_a(), 16'($urandom), 16'($urandom), 16'($urandom));
			endcase
		end
		drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_NAME_EN;
		cfg_wdata = 1'b0;
		grp.valid = 1'b0;
		grp.block_a = 16'd0;
		grp.block_b = 16'd0;
		grp.block_c = 16'd0;
		grp.block_d = 16'd0;
		evt.ready = 1'b0;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		snk_hold = 0;
		errors = 0;
		groups_sent = 0;
		events_seen = 0;
		name_en = 1'b0;
		text_en = 1'b0;
		time_en = 1'b0;
		clear_model();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all reports off: nothing comes back
		write_reg(REG_UNUSED, 1'b1);
		set_enables(1'b0, 1'b0, 1'b0);
		queue_group(16'd0, 16'h0000, 16'd0, 16'd0);
		queue_group(16'h1234, 16'h2001, 16'h4142, 16'h4344);
		queue_group(16'h1234, 16'h4000, 16'h0000, 16'h1234);
		drain();

		set_enables(1'b1, 1'b1, 1'b1);
		// lost data, then a full name twice, then a repeat that changes nothing
		queue_group(16'd0, 16'h0000, 16'd0, 16'd0);
		for (int pass = 0; pass < 2; pass++)
			for (int s = 0; s < 4; s++)
				queue_group(16'hFFFF, 16'h0800 | 16'(s), 16'hFFFF, {8'(65 + 2 * s), 8'(66 + 2 * s)});
		queue_group(16'h0001, 16'h0003, 16'h0000, 16'h4748);
		// text: two segments, back to zero, toggle flag at the last segment, back again
		queue_group(16'h8000, 16'h2000, 16'h4142, 16'h4344);
		queue_group(16'h8000, 16'h2001, 16'h4546, 16'h0047);
		queue_group(16'h8000, 16'h2000, 16'h6162, 16'h6364);
		queue_group(16'h8000, 16'h201F, 16'hFFFE, 16'h8081);
		queue_group(16'h8000, 16'h2010, 16'h3132, 16'h3334);
		// time: plain, wrap forward, wrap backward, every field at maximum, repeat
		queue_group(16'h5555, 16'h4000, 16'h0000, {4'd12, 6'd30, 6'd0});
		queue_group(16'h5555, 16'h4000, 16'h0001, {4'd7, 6'd59, 6'h1F});
		queue_group(16'h5555, 16'h4000, 16'h0000, {4'd0, 6'd0, 6'h3F});
		queue_group(16'h5555, 16'h4000, 16'hFFFF, 16'hFFFF);
		queue_group(16'h5555, 16'h4000, 16'hFFFF, 16'hFFFF);
		// versions and types that are ignored
		queue_group(16'h5555, 16'h2800, 16'h4142, 16'h4344);
		queue_group(16'h5555, 16'h4800, 16'h0000, 16'h1000);
		queue_group(16'h5555, 16'h7000, 16'hFFFF, 16'hFFFF);
		drain();

		src_idle_pct = 31;
		snk_idle_pct = 50;
		random_phase(130);

		set_enables(1'b1, 1'b0, 1'b1);
		src_idle_pct = 50;
		snk_idle_pct = 31;
		random_phase(60);

		// long receiver stall with random groups queued behind it
		set_enables(1'b1, 1'b1, 1'b1);
		snk_hold = 600;
		random_phase(90);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		random_phase(130);

		$display("covered %0d groups and %0d events over four enable settings,",
			groups_sent, events_seen);
		$display("with lost-data clears, idle gaps on both sides and one long output stall");
		if (errors == 0) begin
			$display("** rds_group_decoder_top: PASSED **");
		end else begin
			$display("** rds_group_decoder_top: FAILED **");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rgd_pkg.sv
rtl/rgd_ifs.sv
rtl/rgd_alu.sv
rtl/rgd_text_ram.sv
rtl/rds_group_decoder_top.sv
rtl/rgd_checker.sv
dv/tb_rds_group_decoder_top.sv
